[hw/rtl/windowed_event_rate_meter_macros.svh]
// Assertion macros used by the bound assertion checker in werm_checker.sv.
`ifndef WINDOWED_EVENT_RATE_METER_MACROS_SVH
`define WINDOWED_EVENT_RATE_METER_MACROS_SVH

// Antecedent in this cycle, consequent in the next.
`define WERM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("werm assertion failed");

// Antecedent and consequent in the same cycle.
`define WERM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("werm assertion failed");

`endif

[hw/rtl/werm_pkg.sv]
`timescale 1ns / 1ps

package werm_pkg;

   localparam int BINS       = 64;
   localparam int BIN_MS     = 1000;
   localparam int BIN_AW     = $clog2(BINS);
   localparam int BIN_CNT_W  = $clog2(BINS + 1);
   localparam int BIN_W      = 16;
   localparam int WORD_W     = 2 * BIN_W;
   localparam int MS_W       = 16;
   localparam int SINCE_W    = 10;
   localparam int PIN_W      = 8;
   localparam int KIND_W     = 2;
   localparam int SEL_W      = 2;
   localparam int RATE_W     = 32;
   localparam int WIN_BASE   = (BINS - 1) * BIN_MS;
   localparam int WIN_W      = $clog2(BINS * BIN_MS + 1);
   localparam int SUM_W      = $clog2(2 * BINS * ((1 << BIN_W) - 1) + 1);
   localparam int MS_PER_S   = 1000;
   localparam int Q8_ONE     = 256;
   localparam int RATE_SCALE = MS_PER_S * Q8_ONE;
   localparam int SCALE_W    = $clog2(RATE_SCALE + 1);
   localparam int NUM_W      = SUM_W + SCALE_W + 1;
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [PIN_W-1:0]   AND_PIN_RESET = PIN_W'(5);
   localparam logic [PIN_W-1:0]   XOR_PIN_RESET = PIN_W'(6);
   localparam logic [SINCE_W-1:0] HOLDOFF_RESET = SINCE_W'(30);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_PULSE = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_XOR  = 2'd0,
      SEL_AND  = 2'd1,
      SEL_BOTH = 2'd2
   } sel_type;

   typedef enum logic {
      RES_PULSE = 1'b0,
      RES_RATE  = 1'b1
   } res_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AND_PIN = 2'd0,
      CSR_XOR_PIN = 2'd1,
      CSR_HOLDOFF = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PULSE,
      ST_SUM,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic tick;
      logic pulse_start;
      logic pulse_commit;
      logic sum_start;
      logic sum_step;
      logic mul_load;
      logic div_step;
      logic rate_commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic sum_last;
      logic div_last;
   } status_type;

endpackage

[hw/rtl/werm_req_if.sv]
`timescale 1ns / 1ps

interface werm_req_if;
   logic                          valid;
   logic                          ready;
   logic [werm_pkg::KIND_W-1:0]   kind;
   logic [werm_pkg::PIN_W-1:0]    pin;
   logic [werm_pkg::SEL_W-1:0]    rate_select;

   modport source (output valid, kind, pin, rate_select, input ready);
   modport sink   (input valid, kind, pin, rate_select, output ready);
endinterface

[hw/rtl/werm_rsp_if.sv]
`timescale 1ns / 1ps

interface werm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          result_kind;
   logic [werm_pkg::PIN_W-1:0]    out_pin;
   logic [werm_pkg::RATE_W-1:0]   rate_q8;

   modport source (output valid, result_kind, out_pin, rate_q8, input ready);
   modport sink   (input valid, result_kind, out_pin, rate_q8, output ready);
endinterface

[hw/rtl/werm_div.sv]
`timescale 1ns / 1ps

module werm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         step,
   input  logic [werm_pkg::NUM_W-1:0]   numer,
   input  logic [werm_pkg::WIN_W-1:0]   denom,
   output logic [werm_pkg::NUM_W-1:0]   quot,
   output logic                         last
);

   logic [werm_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [werm_pkg::WIN_W-1:0]     rem_ff, rem_in;
   logic [werm_pkg::WIN_W-1:0]     den_ff, den_in;
   logic [werm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [werm_pkg::WIN_W:0]       trial;
   logic                           fits;

   assign trial = {rem_ff, num_ff[werm_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign quot  = num_ff;
   assign last  = cnt_ff == werm_pkg::DIV_CNT_W'(werm_pkg::NUM_W - 1);

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (load) begin
         num_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = '0;
      end else if (step) begin
         num_in = {num_ff[werm_pkg::NUM_W-2:0], fits};
         rem_in = fits ? werm_pkg::WIN_W'(trial - {1'b0, den_ff})
                       : trial[werm_pkg::WIN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hw/rtl/werm_dp.sv]
`timescale 1ns / 1ps

module werm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  werm_pkg::cmd_type                 cmd,
   output werm_pkg::status_type              status,
   input  logic [werm_pkg::PIN_W-1:0]        req_pin,
   input  logic [werm_pkg::SEL_W-1:0]        req_rate_select,
   input  logic                              csr_write_enable,
   input  logic [werm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [werm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic [werm_pkg::PIN_W-1:0]        rsp_out_pin,
   output logic [werm_pkg::RATE_W-1:0]       rsp_rate_q8
);

   localparam logic [werm_pkg::MS_W-1:0] BIN_MS_V = werm_pkg::MS_W'(werm_pkg::BIN_MS);
   localparam logic [werm_pkg::NUM_W-1:0] RATE_SAT = werm_pkg::NUM_W'(64'hFFFF_FFFF);

   logic [werm_pkg::PIN_W-1:0]    and_pin_ff, and_pin_in;
   logic [werm_pkg::PIN_W-1:0]    xor_pin_ff, xor_pin_in;
   logic [werm_pkg::SINCE_W-1:0]  holdoff_ff, holdoff_in;

   logic [werm_pkg::WORD_W-1:0]   mem [werm_pkg::BINS];
   logic [werm_pkg::BINS-1:0]     valid_ff, valid_in;
   logic [werm_pkg::WORD_W-1:0]   rd_word_ff;
   logic                          rd_valid_ff;
   logic [werm_pkg::BIN_AW-1:0]   rd_addr;
   logic                          mem_we;
   logic [werm_pkg::WORD_W-1:0]   wr_word;
   logic [werm_pkg::WORD_W-1:0]   entry;

   logic [werm_pkg::BIN_AW-1:0]   newest_ff, newest_in;
   logic [werm_pkg::MS_W-1:0]     ms_ff, ms_in, ms_inc;
   logic [werm_pkg::SINCE_W-1:0]  and_since_ff, and_since_in;
   logic [werm_pkg::SINCE_W-1:0]  xor_since_ff, xor_since_in;

   logic [werm_pkg::PIN_W-1:0]    pin_ff, pin_in;
   logic [werm_pkg::SEL_W-1:0]    sel_ff, sel_in;
   logic [werm_pkg::BIN_CNT_W-1:0] cnt_ff, cnt_in;
   logic [werm_pkg::SUM_W-1:0]    acc_ff, acc_in;
   logic [werm_pkg::BIN_W:0]      part;

   logic [werm_pkg::BIN_W-1:0]    and_bin, xor_bin, and_bin_new, xor_bin_new;
   logic                          and_hit, xor_hit, and_block, xor_act, xor_block, forward;

   logic [werm_pkg::WIN_W-1:0]    win;
   logic [werm_pkg::NUM_W-1:0]    numer, quot;
   logic                          div_last;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [werm_pkg::PIN_W-1:0]    rsp_pin_ff, rsp_pin_in;
   logic [werm_pkg::RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;

   // configuration
   always_comb begin
      and_pin_in = and_pin_ff;
      xor_pin_in = xor_pin_ff;
      holdoff_in = holdoff_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            werm_pkg::CSR_AND_PIN: and_pin_in = csr_write_data[werm_pkg::PIN_W-1:0];
            werm_pkg::CSR_XOR_PIN: xor_pin_in = csr_write_data[werm_pkg::PIN_W-1:0];
            werm_pkg::CSR_HOLDOFF: holdoff_in = csr_write_data[werm_pkg::SINCE_W-1:0];
            default: ;
         endcase
      end
   end

   // bin memory
   assign entry   = rd_valid_ff ? rd_word_ff : '0;
   assign and_bin = entry[werm_pkg::WORD_W-1:werm_pkg::BIN_W];
   assign xor_bin = entry[werm_pkg::BIN_W-1:0];

   always_comb begin
      rd_addr = newest_ff;
      if (cmd.sum_start) begin
         rd_addr = '0;
      end else if (cmd.sum_step && !status.sum_last) begin
         rd_addr = cnt_ff[werm_pkg::BIN_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[newest_ff] <= wr_word;
      end
      rd_word_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // pulse decision
   assign and_hit   = pin_ff == and_pin_ff;
   assign xor_hit   = pin_ff == xor_pin_ff;
   assign and_block = and_hit && (and_since_ff < holdoff_ff);
   assign xor_act   = xor_hit && !and_block;
   assign xor_block = xor_act && (xor_since_ff < holdoff_ff);
   assign forward   = !and_block && !xor_block;

   assign and_bin_new = (and_hit && and_bin != '1) ? and_bin + 1'b1 : and_bin;
   assign xor_bin_new = (xor_act && xor_bin != '1) ? xor_bin + 1'b1 : xor_bin;
   assign wr_word     = {and_bin_new, xor_bin_new};
   assign mem_we      = cmd.pulse_commit && (and_hit || xor_hit);

   // time base, bins ring and holdoff counters
   assign ms_inc = ms_ff + 1'b1;

   always_comb begin
      valid_in     = valid_ff;
      newest_in    = newest_ff;
      ms_in        = ms_ff;
      and_since_in = and_since_ff;
      xor_since_in = xor_since_ff;
      if (cmd.tick) begin
         ms_in = ms_inc;
         if (and_since_ff != '1) begin
            and_since_in = and_since_ff + 1'b1;
         end
         if (xor_since_ff != '1) begin
            xor_since_in = xor_since_ff + 1'b1;
         end
         if (ms_inc > BIN_MS_V) begin
            ms_in     = ms_inc - BIN_MS_V;
            newest_in = (newest_ff == '0) ? werm_pkg::BIN_AW'(werm_pkg::BINS - 1)
                                          : newest_ff - 1'b1;
            valid_in[newest_in] = 1'b0;
         end
      end else if (cmd.pulse_commit) begin
         if (mem_we) begin
            valid_in[newest_ff] = 1'b1;
         end
         if (and_hit && !and_block) begin
            and_since_in = '0;
         end
         if (xor_act && !xor_block) begin
            xor_since_in = '0;
         end
      end
   end

   // item capture and bin sweep
   always_comb begin
      unique case (sel_ff)
         werm_pkg::SEL_XOR:  part = {1'b0, xor_bin};
         werm_pkg::SEL_AND:  part = {1'b0, and_bin};
         werm_pkg::SEL_BOTH: part = {1'b0, and_bin} + {1'b0, xor_bin};
         default:            part = '0;
      endcase
   end

   always_comb begin
      pin_in = pin_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      if (cmd.pulse_start) begin
         pin_in = req_pin;
      end
      if (cmd.sum_start) begin
         sel_in = req_rate_select;
         cnt_in = werm_pkg::BIN_CNT_W'(1);
         acc_in = '0;
      end else if (cmd.sum_step) begin
         acc_in = acc_ff + werm_pkg::SUM_W'(part);
         if (!status.sum_last) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // rate division
   assign win   = werm_pkg::WIN_W'(werm_pkg::WIN_BASE) + werm_pkg::WIN_W'(ms_ff);
   assign numer = werm_pkg::NUM_W'(acc_ff) * werm_pkg::NUM_W'(werm_pkg::RATE_SCALE)
                + werm_pkg::NUM_W'(win >> 1);

   werm_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (cmd.mul_load),
      .step  (cmd.div_step),
      .numer (numer),
      .denom (win),
      .quot  (quot),
      .last  (div_last)
   );

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pin_in   = rsp_pin_ff;
      rsp_rate_in  = rsp_rate_ff;
      if (cmd.pulse_commit && forward) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = werm_pkg::RES_PULSE;
         rsp_pin_in   = pin_ff;
         rsp_rate_in  = '0;
      end else if (cmd.rate_commit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = werm_pkg::RES_RATE;
         rsp_pin_in   = '0;
         rsp_rate_in  = (quot > RATE_SAT) ? '1 : quot[werm_pkg::RATE_W-1:0];
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.sum_last = cnt_ff == werm_pkg::BIN_CNT_W'(werm_pkg::BINS);
   assign status.div_last = div_last;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_pin     = rsp_pin_ff;
   assign rsp_rate_q8     = rsp_rate_ff;

   always_ff @(posedge clock) begin
      pin_ff      <= pin_in;
      sel_ff      <= sel_in;
      acc_ff      <= acc_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pin_ff  <= rsp_pin_in;
      rsp_rate_ff <= rsp_rate_in;
      if (reset) begin
         and_pin_ff   <= werm_pkg::AND_PIN_RESET;
         xor_pin_ff   <= werm_pkg::XOR_PIN_RESET;
         holdoff_ff   <= werm_pkg::HOLDOFF_RESET;
         valid_ff     <= '0;
         newest_ff    <= '0;
         ms_ff        <= '0;
         and_since_ff <= '0;
         xor_since_ff <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         and_pin_ff   <= and_pin_in;
         xor_pin_ff   <= xor_pin_in;
         holdoff_ff   <= holdoff_in;
         valid_ff     <= valid_in;
         newest_ff    <= newest_in;
         ms_ff        <= ms_in;
         and_since_ff <= and_since_in;
         xor_since_ff <= xor_since_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/werm_ctrl.sv]
`timescale 1ns / 1ps

module werm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [werm_pkg::KIND_W-1:0]   req_kind,
   input  werm_pkg::status_type          status,
   output werm_pkg::cmd_type             cmd
);

   werm_pkg::state_type state_ff, state_in;
   logic                accept;

   assign req_ready = (state_ff == werm_pkg::ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         werm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  werm_pkg::KIND_PULSE: state_in = werm_pkg::ST_PULSE;
                  werm_pkg::KIND_QUERY: state_in = werm_pkg::ST_SUM;
                  default:              state_in = werm_pkg::ST_IDLE;
               endcase
            end
         end
         werm_pkg::ST_PULSE: begin
            if (status.out_free) begin
               state_in = werm_pkg::ST_IDLE;
            end
         end
         werm_pkg::ST_SUM: begin
            if (status.sum_last) begin
               state_in = werm_pkg::ST_MUL;
            end
         end
         werm_pkg::ST_MUL: state_in = werm_pkg::ST_DIV;
         werm_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = werm_pkg::ST_DONE;
            end
         end
         werm_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = werm_pkg::ST_IDLE;
            end
         end
         default: state_in = werm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         werm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  werm_pkg::KIND_TICK:  cmd.tick        = 1'b1;
                  werm_pkg::KIND_PULSE: cmd.pulse_start = 1'b1;
                  werm_pkg::KIND_QUERY: cmd.sum_start   = 1'b1;
                  default: ;
               endcase
            end
         end
         werm_pkg::ST_PULSE: cmd.pulse_commit = status.out_free;
         werm_pkg::ST_SUM:   cmd.sum_step     = 1'b1;
         werm_pkg::ST_MUL:   cmd.mul_load     = 1'b1;
         werm_pkg::ST_DIV:   cmd.div_step     = 1'b1;
         werm_pkg::ST_DONE:  cmd.rate_commit  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= werm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/windowed_event_rate_meter.sv]
`timescale 1ns / 1ps

// Windowed event rate meter. A tick item is taken in the idle state and the
// block is ready again in the next cycle. A pulse reads the newest bin, then
// updates it once the result register is free. A rate query sweeps the 64
// bins of 1000 ms in the bin memory in turn, loads the restoring divider,
// which then yields one quotient bit per cycle, and commits the rate once the
// result register is free. Bins are cleared by per-entry valid bits, so no
// clearing pass follows reset.

module windowed_event_rate_meter (
   input  logic                              clock,
   input  logic                              reset,
   werm_req_if.sink                          req_port,
   werm_rsp_if.source                        rsp_port,
   input  logic                              csr_write_enable,
   input  logic [werm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [werm_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   werm_pkg::cmd_type    cmd;
   werm_pkg::status_type status;

   werm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .req_kind  (req_port.kind),
      .status    (status),
      .cmd       (cmd)
   );

   werm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pin          (req_port.pin),
      .req_rate_select  (req_port.rate_select),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_port.valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_result_kind  (rsp_port.result_kind),
      .rsp_out_pin      (rsp_port.out_pin),
      .rsp_rate_q8      (rsp_port.rate_q8)
   );

endmodule

[hw/rtl/werm_checker.sv]
`timescale 1ns / 1ps
`include "windowed_event_rate_meter_macros.svh"

module werm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [werm_pkg::KIND_W-1:0]   req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_result_kind,
   input logic [werm_pkg::PIN_W-1:0]    rsp_out_pin,
   input logic [werm_pkg::RATE_W-1:0]   rsp_rate_q8
);

   `WERM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rate_q8) && $stable(rsp_out_pin) && $stable(rsp_result_kind))
   `WERM_ASSERT_NOW(a_pulse_no_rate, clock, reset, rsp_valid && rsp_result_kind == werm_pkg::RES_PULSE, rsp_rate_q8 == '0)
   `WERM_ASSERT_NOW(a_rate_no_pin, clock, reset, rsp_valid && rsp_result_kind == werm_pkg::RES_RATE, rsp_out_pin == '0)
   `WERM_ASSERT_NEXT(a_busy_after_item, clock, reset, req_valid && req_ready && (req_kind == werm_pkg::KIND_PULSE || req_kind == werm_pkg::KIND_QUERY), !req_ready)
   `WERM_ASSERT_NEXT(a_tick_ready, clock, reset, req_valid && req_ready && req_kind == werm_pkg::KIND_TICK, req_ready)

endmodule

bind windowed_event_rate_meter werm_checker u_werm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .req_kind        (req_port.kind),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_result_kind (rsp_port.result_kind),
   .rsp_out_pin     (rsp_port.out_pin),
   .rsp_rate_q8     (rsp_port.rate_q8)
);

[tb/werm_checker.sv]
`timescale 1ns / 1ps

module werm_tb_checker
   import werm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   werm_req_if                     req_mon,
   werm_rsp_if                     rsp_mon,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output int                      fail_count,
   output int                      pending_count
);

   localparam int PRINT_CAP = 60;

   typedef struct {
      res_kind_type         kind;
      logic [PIN_W-1:0]     pin;
      logic [RATE_W-1:0]    rate;
   } answer_type;

   logic [PIN_W-1:0]   and_pin;
   logic [PIN_W-1:0]   xor_pin;
   logic [SINCE_W-1:0] holdoff;
   logic [BIN_W-1:0]   and_count [BINS];
   logic [BIN_W-1:0]   xor_count [BINS];
   int                 open_slot;
   logic [MS_W-1:0]    ms_open;
   logic [SINCE_W-1:0] and_quiet;
   logic [SINCE_W-1:0] xor_quiet;
   answer_type         answers_due [$];
   int                 mismatches;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic logic [RATE_W-1:0] window_rate(input logic [SEL_W-1:0] sel);
      logic [63:0] total;
      logic [63:0] span;
      logic [63:0] scaled;
      int i;
      total = '0;
      for (i = 0; i < BINS; i++) begin
         if (sel == SEL_XOR || sel == SEL_BOTH) total += 64'(xor_count[i]);
         if (sel == SEL_AND || sel == SEL_BOTH) total += 64'(and_count[i]);
      end
      span = 64'(WIN_BASE) + 64'(ms_open);
      scaled = (total * 64'(RATE_SCALE) + span / 2) / span;
      return (scaled > 64'hFFFF_FFFF) ? '1 : scaled[RATE_W-1:0];
   endfunction

   task automatic advance_meter(input logic [KIND_W-1:0] kind, input logic [PIN_W-1:0] pin,
                                input logic [SEL_W-1:0] sel);
      answer_type word;
      logic       forward;
      forward = 1'b1;
      case (kind)
         KIND_TICK: begin
            ms_open = ms_open + 1'b1;
            if (and_quiet != '1) and_quiet = and_quiet + 1'b1;
            if (xor_quiet != '1) xor_quiet = xor_quiet + 1'b1;
            if (ms_open > MS_W'(BIN_MS)) begin
               open_slot = (open_slot == 0) ? BINS - 1 : open_slot - 1;
               and_count[open_slot] = '0;
               xor_count[open_slot] = '0;
               ms_open = ms_open - MS_W'(BIN_MS);
            end
         end
         KIND_PULSE: begin
            if (pin == and_pin) begin
               if (and_count[open_slot] != '1) begin
                  and_count[open_slot] = and_count[open_slot] + 1'b1;
               end
               if (and_quiet < holdoff) forward = 1'b0;
               else and_quiet = '0;
            end
            if (forward && pin == xor_pin) begin
               if (xor_count[open_slot] != '1) begin
                  xor_count[open_slot] = xor_count[open_slot] + 1'b1;
               end
               if (xor_quiet < holdoff) forward = 1'b0;
               else xor_quiet = '0;
            end
            if (forward) begin
               word.kind = RES_PULSE;
               word.pin  = pin;
               word.rate = '0;
               answers_due.insert(answers_due.size(), word);
            end
         end
         KIND_QUERY: begin
            word.kind = RES_RATE;
            word.pin  = '0;
            word.rate = window_rate(sel);
            answers_due.insert(answers_due.size(), word);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         and_pin     = AND_PIN_RESET;
         xor_pin     = XOR_PIN_RESET;
         holdoff     = HOLDOFF_RESET;
         and_count   = '{default: '0};
         xor_count   = '{default: '0};
         open_slot   = 0;
         ms_open     = '0;
         and_quiet   = '0;
         xor_quiet   = '0;
         mismatches  = 0;
         answers_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_mon.result_kind), 64'(0));
            end else begin
               due = answers_due.pop_front();
               if (rsp_mon.result_kind !== due.kind) begin
                  report_mismatch("result_kind", 64'(rsp_mon.result_kind), 64'(due.kind));
               end
               if (rsp_mon.out_pin !== due.pin) begin
                  report_mismatch("out_pin", 64'(rsp_mon.out_pin), 64'(due.pin));
               end
               if (rsp_mon.rate_q8 !== due.rate) begin
                  report_mismatch("rate_q8", 64'(rsp_mon.rate_q8), 64'(due.rate));
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AND_PIN: and_pin = csr_write_data[PIN_W-1:0];
               CSR_XOR_PIN: xor_pin = csr_write_data[PIN_W-1:0];
               CSR_HOLDOFF: holdoff = csr_write_data[SINCE_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_meter(req_mon.kind, req_mon.pin, req_mon.rate_select);
         end
      end
      fail_count    <= mismatches;
      pending_count <= answers_due.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import werm_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 150;
   localparam int LONG_HOLD     = 600;
   localparam int LONG_TICKS    = 1030;
   localparam int PHASE_WORDS   = 60;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [SEL_W-1:0]  SEL_UNUSED  = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    fail_count;
   int                    pending_count;

   logic [PIN_W-1:0]      live_and;
   logic [PIN_W-1:0]      live_xor;
   int                    burst_left = 0;
   bit                    steady = 1'b0;
   logic                  hold_request = 1'b0;
   logic                  hold_done;
   int                    hold_left;
   int                    mode_left;
   int                    ready_mode;
   int                    idle_cycles;

   werm_req_if req_if ();
   werm_rsp_if rsp_if ();

   windowed_event_rate_meter dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   werm_tb_checker rate_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_done    <= 1'b0;
         hold_left    <= 0;
         mode_left    <= 0;
         ready_mode   <= 0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_if.ready <= 1'b0;
         hold_done    <= 1'b1;
         hold_left    <= LONG_HOLD;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(8, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("windowed_event_rate_meter verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PIN_W-1:0] pin,
                            input logic [SEL_W-1:0] sel);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.pin         <= pin;
      req_if.rate_select <= sel;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [PIN_W-1:0] and_p, input logic [PIN_W-1:0] xor_p,
                             input logic [SINCE_W-1:0] hold);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_AND_PIN;
      csr_write_data   <= CSR_DATA_W'(and_p);
      @(posedge clock);
      csr_index        <= CSR_XOR_PIN;
      csr_write_data   <= CSR_DATA_W'(xor_p);
      @(posedge clock);
      csr_index        <= CSR_HOLDOFF;
      csr_write_data   <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_and = and_p;
      live_xor = xor_p;
   endtask

   task automatic random_phase(input int words);
      int n;
      int pick;
      int run;
      logic [PIN_W-1:0] pin;
      for (n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_word(KIND_TICK, PIN_W'($urandom), SEL_W'($urandom));
         end else if (pick < 40) begin
            run = $urandom_range(2, 20);
            repeat (run) send_word(KIND_TICK, PIN_W'($urandom), SEL_W'($urandom));
         end else if (pick < 75) begin
            case ($urandom_range(0, 9))
               0, 1, 2: pin = live_and;
               3, 4, 5: pin = live_xor;
               default: pin = PIN_W'($urandom);
            endcase
            send_word(KIND_PULSE, pin, SEL_W'($urandom));
         end else if (pick < 95) begin
            send_word(KIND_QUERY, PIN_W'($urandom), SEL_W'($urandom_range(0, 3)));
         end else begin
            send_word(KIND_UNUSED, PIN_W'($urandom), SEL_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [PIN_W-1:0] shared_pin;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.kind        <= KIND_TICK;
      req_if.pin         <= '0;
      req_if.rate_select <= SEL_XOR;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_AND_PIN;
      csr_write_data     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      live_and = AND_PIN_RESET;
      live_xor = XOR_PIN_RESET;

      send_word(KIND_QUERY, '0, SEL_XOR);
      send_word(KIND_QUERY, '0, SEL_AND);
      send_word(KIND_QUERY, '0, SEL_BOTH);
      send_word(KIND_QUERY, '1, SEL_UNUSED);
      send_word(KIND_PULSE, AND_PIN_RESET, SEL_XOR);
      send_word(KIND_PULSE, XOR_PIN_RESET, SEL_XOR);
      send_word(KIND_PULSE, 8'h00, SEL_UNUSED);
      send_word(KIND_PULSE, 8'hFF, SEL_BOTH);
      send_word(KIND_UNUSED, AND_PIN_RESET, SEL_BOTH);
      send_word(KIND_QUERY, '0, SEL_BOTH);
      wait_for_idle();

      set_config(8'd7, 8'd7, 10'd2);
      send_word(KIND_TICK, '0, SEL_XOR);
      send_word(KIND_TICK, '0, SEL_XOR);
      send_word(KIND_PULSE, 8'd7, SEL_XOR);
      send_word(KIND_PULSE, 8'd7, SEL_XOR);
      send_word(KIND_TICK, '0, SEL_XOR);
      send_word(KIND_PULSE, 8'd7, SEL_XOR);
      send_word(KIND_QUERY, '0, SEL_AND);
      send_word(KIND_QUERY, '0, SEL_XOR);
      send_word(KIND_QUERY, '0, SEL_BOTH);
      wait_for_idle();

      set_config(8'h00, 8'hFF, 10'd0);
      hold_request <= 1'b1;
      repeat (20) send_word(KIND_PULSE, PIN_W'($urandom), SEL_W'($urandom));
      random_phase(PHASE_WORDS);
      wait_for_idle();

      set_config(8'hFF, 8'h00, 10'd1023);
      random_phase(PHASE_WORDS);
      wait_for_idle();

      shared_pin = PIN_W'($urandom);
      set_config(shared_pin, shared_pin, SINCE_W'($urandom_range(1, 40)));
      random_phase(PHASE_WORDS);
      wait_for_idle();

      set_config(PIN_W'($urandom), PIN_W'($urandom), SINCE_W'($urandom));
      random_phase(PHASE_WORDS);
      wait_for_idle();

      set_config(AND_PIN_RESET, XOR_PIN_RESET, HOLDOFF_RESET);
      random_phase(PHASE_WORDS);
      wait_for_idle();

      // run the holdoff counters to their limit and open a fresh bin
      set_config(8'd17, 8'd18, 10'd1023);
      steady = 1'b1;
      repeat (LONG_TICKS) send_word(KIND_TICK, PIN_W'($urandom), SEL_W'($urandom));
      steady = 1'b0;
      send_word(KIND_PULSE, live_and, SEL_W'($urandom));
      send_word(KIND_PULSE, live_xor, SEL_W'($urandom));
      send_word(KIND_PULSE, live_and, SEL_W'($urandom));
      send_word(KIND_PULSE, live_xor, SEL_W'($urandom));
      send_word(KIND_QUERY, '0, SEL_XOR);
      send_word(KIND_QUERY, '0, SEL_AND);
      send_word(KIND_QUERY, '0, SEL_BOTH);
      wait_for_idle();

      if (fail_count == 0) begin
         $display("windowed_event_rate_meter verification clean");
      end else begin
         $display("windowed_event_rate_meter verification failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/werm_pkg.sv
hw/rtl/werm_req_if.sv
hw/rtl/werm_rsp_if.sv
hw/rtl/werm_div.sv
hw/rtl/werm_dp.sv
hw/rtl/werm_ctrl.sv
hw/rtl/windowed_event_rate_meter.sv
hw/rtl/werm_checker.sv
tb/werm_checker.sv
tb/tb_top.sv
